// ===== hdl/rfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// Radiometer frame sample demux package
// Shared constants, the word job record and frame layout positions.
// ----------------------------------------------------------------------------
package rfsd_pkg;

   // Frame layout.
   localparam logic [7:0] POS_FRAME_FIRST = 8'd0;
   localparam logic [7:0] POS_MARK_A      = 8'd4;
   localparam logic [7:0] POS_MARK_B      = 8'd5;
   localparam logic [7:0] HALF0_FIRST     = 8'd8;
   localparam logic [7:0] HALF0_LAST      = 8'd125;
   localparam logic [7:0] HALF1_FIRST     = 8'd128;
   localparam logic [7:0] HALF1_LAST      = 8'd245;
   localparam logic [7:0] POS_SATURATE    = 8'd255;

   // Header checks.
   localparam logic [7:0] MARKER_BYTE = 8'd255;
   localparam logic [7:0] COUNTER_MIN = 8'd2;
   localparam logic [7:0] COUNTER_MAX = 8'd26;

   // Word position boundaries of the three resolution groups.
   localparam logic [5:0] LOW_WORD_END  = 6'd5;
   localparam logic [5:0] FULL_WORD_END = 6'd13;
   localparam logic [4:0] FULL_CH_FIRST = 5'd5;
   localparam logic [4:0] MED_CH_FIRST  = 5'd7;

   // Samples per word, minus one.
   localparam logic [1:0] LOW_CNT_M1  = 2'd3;
   localparam logic [1:0] FULL_CNT_M1 = 2'd0;
   localparam logic [1:0] MED_CNT_M1  = 2'd1;

   localparam logic [15:0] SIGN_FLIP = 16'h8000;

   localparam int LINE_BITS_DEF = 16;
   localparam int LINE_IDX_W    = 16;
   localparam int QUEUE_DEPTH   = 2;

   // One completed word, ready to be expanded into samples.
   typedef struct packed {
      logic [15:0]           word;
      logic [4:0]            channel;
      logic [7:0]            column;
      logic [1:0]            count_m1;
      logic [LINE_IDX_W-1:0] line;
   } job_type;

endpackage

// ===== hdl/rfsd_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel interface
// Carries one raw frame byte and its frame start flag per request.
// ----------------------------------------------------------------------------
interface rfsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       frame_start;

   modport source (output valid, output frame_byte, output frame_start, input ready);
   modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ===== hdl/rfsd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel interface
// Carries one demultiplexed sample per transfer.
// ----------------------------------------------------------------------------
interface rfsd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_value;
   logic [4:0]         channel_id;
   logic [7:0]         column_index;
   logic [15:0]        line_index;
   logic               last_of_run;

   modport source (output valid, output sample_value, output channel_id,
                   output column_index, output line_index, output last_of_run,
                   input ready);
   modport sink   (input valid, input sample_value, input channel_id,
                   input column_index, input line_index, input last_of_run,
                   output ready);
endinterface

// ===== hdl/rfsd_front.sv =====
// ----------------------------------------------------------------------------
// Frame front end
// Tracks the byte position, checks the frame header and assembles words.
// ----------------------------------------------------------------------------
module rfsd_front
   import rfsd_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         byte_order_mode,
   rfsd_req_if.sink     req_bus,
   input  logic         q_full,
   output logic         push,
   output job_type      job
);

   logic [7:0]           byte_position_ff, byte_position_in;
   logic                 frame_valid_ff, frame_valid_in;
   logic [4:0]           scan_counter_ff, scan_counter_in;
   logic [7:0]           held_byte_ff, held_byte_in;
   logic [LINE_BITS-1:0] line_count_ff, line_count_in;

   logic       accept;
   logic [7:0] pos, b, marker, cnt;
   logic       fv, in_half0, in_half1;
   logic [7:0] off;
   logic [5:0] w, t;
   logic [7:0] col_base;
   logic [1:0] first;
   logic [31:0] line_ext;

   assign req_bus.ready = !q_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign b = req_bus.frame_byte;

   always_comb begin
      pos = req_bus.frame_start ? POS_FRAME_FIRST : byte_position_ff;
      fv  = req_bus.frame_start ? 1'b0 : frame_valid_ff;
      in_half0 = (pos >= HALF0_FIRST) && (pos <= HALF0_LAST);
      in_half1 = (pos >= HALF1_FIRST) && (pos <= HALF1_LAST);
      off = in_half1 ? (pos - HALF1_FIRST) : (pos - HALF0_FIRST);
      w   = off[6:1];
      marker = byte_order_mode ? b : held_byte_ff;
      cnt    = byte_order_mode ? held_byte_ff : b;
      col_base = {scan_counter_ff - 5'd2, 3'b000} + {5'd0, in_half1, 2'b00};
      line_ext = 32'(line_count_ff);

      t = 6'd0;
      job.word = byte_order_mode ? {held_byte_ff, b} : {b, held_byte_ff};
      job.line = line_ext[LINE_IDX_W-1:0];
      if (w < LOW_WORD_END) begin
         job.channel  = w[4:0];
         first        = 2'd0;
         job.count_m1 = LOW_CNT_M1;
      end else if (w < FULL_WORD_END) begin
         t = w - LOW_WORD_END;
         job.channel  = FULL_CH_FIRST + {3'd0, t[3:2]};
         first        = t[1:0];
         job.count_m1 = FULL_CNT_M1;
      end else begin
         t = w - FULL_WORD_END;
         job.channel  = MED_CH_FIRST + t[5:1];
         first        = {t[0], 1'b0};
         job.count_m1 = MED_CNT_M1;
      end
      job.column = col_base + {6'd0, first};

      byte_position_in = byte_position_ff;
      frame_valid_in   = frame_valid_ff;
      scan_counter_in  = scan_counter_ff;
      held_byte_in     = held_byte_ff;
      line_count_in    = line_count_ff;
      push             = 1'b0;

      if (accept) begin
         byte_position_in = (pos != POS_SATURATE) ? pos + 8'd1 : pos;
         frame_valid_in   = fv;
         if (pos == POS_FRAME_FIRST) begin
            frame_valid_in = 1'b0;
         end else if (pos == POS_MARK_A) begin
            held_byte_in = b;
         end else if (pos == POS_MARK_B) begin
            if (marker == MARKER_BYTE && cnt >= COUNTER_MIN && cnt <= COUNTER_MAX) begin
               frame_valid_in  = 1'b1;
               scan_counter_in = cnt[4:0];
            end else begin
               frame_valid_in = 1'b0;
            end
         end else if (in_half0 || in_half1) begin
            if (!off[0]) begin
               held_byte_in = b;
            end else if (fv) begin
               push = 1'b1;
               // The last word of the final scan of a line closes the line.
               if (pos == HALF1_LAST && scan_counter_ff == COUNTER_MAX[4:0]) begin
                  line_count_in = line_count_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         frame_valid_ff   <= 1'b0;
         scan_counter_ff  <= '0;
         held_byte_ff     <= '0;
         line_count_ff    <= '0;
      end else begin
         byte_position_ff <= byte_position_in;
         frame_valid_ff   <= frame_valid_in;
         scan_counter_ff  <= scan_counter_in;
         held_byte_ff     <= held_byte_in;
         line_count_ff    <= line_count_in;
      end
   end

endmodule

// ===== hdl/rfsd_queue.sv =====
// ----------------------------------------------------------------------------
// Word job queue
// Short FIFO that decouples word assembly from sample expansion.
// ----------------------------------------------------------------------------
module rfsd_queue
   import rfsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_job = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("job pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("job popped from an empty queue");

endmodule

// ===== hdl/rfsd_back.sv =====
// ----------------------------------------------------------------------------
// Sample expander
// Turns each word job into one, two or four samples in an output register.
// ----------------------------------------------------------------------------
module rfsd_back
   import rfsd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  job_type   head_job,
   output logic      pop,
   rfsd_rsp_if.source rsp_bus
);

   job_type     job_ff, job_in;
   logic        busy_ff, busy_in;
   logic [1:0]  idx_ff, idx_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_value_ff, out_value_in;
   logic [4:0]  out_channel_ff, out_channel_in;
   logic [7:0]  out_column_ff, out_column_in;
   logic [15:0] out_line_ff, out_line_in;
   logic        out_last_ff, out_last_in;

   job_type    cur;
   logic [1:0] cur_idx;
   logic       out_free, emit, is_last;

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      cur      = busy_ff ? job_ff : head_job;
      cur_idx  = busy_ff ? idx_ff : 2'd0;
      emit     = out_free && (busy_ff || !q_empty);
      is_last  = (cur_idx == cur.count_m1);
      pop      = emit && !busy_ff;

      job_in         = job_ff;
      busy_in        = busy_ff;
      idx_in         = idx_ff;
      out_valid_in   = out_valid_ff && !rsp_bus.ready;
      out_value_in   = out_value_ff;
      out_channel_in = out_channel_ff;
      out_column_in  = out_column_ff;
      out_line_in    = out_line_ff;
      out_last_in    = out_last_ff;

      if (emit) begin
         out_valid_in   = 1'b1;
         out_value_in   = cur.word ^ SIGN_FLIP;
         out_channel_in = cur.channel;
         out_column_in  = cur.column + {6'd0, cur_idx};
         out_line_in    = cur.line;
         out_last_in    = is_last;
         job_in         = cur;
         busy_in        = !is_last;
         idx_in         = cur_idx + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      out_value_ff   <= out_value_in;
      out_channel_ff <= out_channel_in;
      out_column_ff  <= out_column_in;
      out_line_ff    <= out_line_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.sample_value = $signed(out_value_ff);
   assign rsp_bus.channel_id   = out_channel_ff;
   assign rsp_bus.column_index = out_column_ff;
   assign rsp_bus.line_index   = out_line_ff;
   assign rsp_bus.last_of_run  = out_last_ff;

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (idx_ff <= job_ff.count_m1))
      else $error("sample index ran past the word's sample count");
   a_low_last_column: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff && out_channel_ff < FULL_CH_FIRST)
         |-> (out_column_ff[1:0] == 2'd3))
      else $error("low resolution word did not end on its fourth column");

endmodule

// ===== hdl/radiometer_frame_sample_demux_core.sv =====
// ----------------------------------------------------------------------------
// Radiometer frame sample demux core
// Splits scan frames into per-channel samples with column and line indexes.
// ----------------------------------------------------------------------------
// A word's completing request pushes its job into the queue; the expander then
// registers its first sample at the output and the others follow one a cycle
// while the response side is ready. Throughput: one request per cycle while
// the job queue has room; the expander emits one sample per cycle while the
// response side is ready, so four-sample words can fill the queue and hold
// back requests. Reset is synchronous and active high; it clears the byte
// position, frame state, line count, queue, output and mode.
// ----------------------------------------------------------------------------
module radiometer_frame_sample_demux_core
   import rfsd_pkg::*;
#(
   parameter int LINE_BITS = LINE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rfsd_req_if.sink   req_bus,
   rfsd_rsp_if.source rsp_bus,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   // The single configuration bit selects which header byte holds the
   // marker and whether words arrive most significant byte first.
   logic byte_order_mode_ff, byte_order_mode_in;

   // Front end to queue, queue to sample expander.
   logic    push, pop, q_full, q_empty;
   job_type push_job, head_job;

   assign byte_order_mode_in = csr_wr_en ? csr_wr_data : byte_order_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_order_mode_ff <= 1'b0;
      end else begin
         byte_order_mode_ff <= byte_order_mode_in;
      end
   end

   // The front end accepts a request whenever the queue is not full; every
   // second byte of a valid frame's data area yields one word job, which
   // already carries the line index in force when the word completed.
   rfsd_front #(
      .LINE_BITS (LINE_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .byte_order_mode (byte_order_mode_ff),
      .req_bus         (req_bus),
      .q_full          (q_full),
      .push            (push),
      .job             (push_job)
   );

   rfsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // The expander drains jobs into a registered output, so a stalled
   // response side only backs up the queue and not the byte intake at once.
   rfsd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .head_job (head_job),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
